/* rtl/core/obd2rd_pkg.sv */
// Shared types and constants for the OBD-II response decoder.
// Holds the input word, result and decoder state structures; no dependencies.
package obd2rd_pkg;

    localparam int unsigned MAX_DTC = 16;

    localparam logic [7:0] MODE_CURRENT   = 8'h01;
    localparam logic [7:0] MODE_STORED    = 8'h03;
    localparam logic [7:0] MODE_PENDING   = 8'h07;
    localparam logic [7:0] MODE_PERMANENT = 8'h0A;

    localparam logic [7:0] PID_MONITORS = 8'h01;
    localparam logic [7:0] PID_RPM      = 8'h0C;
    localparam logic [7:0] PID_SPEED    = 8'h0D;
    localparam logic [7:0] PID_COOLANT  = 8'h05;
    localparam logic [7:0] PID_FUEL     = 8'h2F;
    localparam logic [7:0] PID_LOAD     = 8'h04;

    localparam logic [2:0] TGT_RPM       = 3'd0;
    localparam logic [2:0] TGT_SPEED     = 3'd1;
    localparam logic [2:0] TGT_COOLANT   = 3'd2;
    localparam logic [2:0] TGT_FUEL      = 3'd3;
    localparam logic [2:0] TGT_LOAD      = 3'd4;
    localparam logic [2:0] TGT_STORED    = 3'd0;
    localparam logic [2:0] TGT_PENDING   = 3'd1;
    localparam logic [2:0] TGT_PERMANENT = 3'd2;

    typedef enum logic [2:0] {
        KIND_SCALAR        = 3'd0,
        KIND_DTC_ENTRY     = 3'd1,
        KIND_READY_VALID   = 3'd2,
        KIND_READY_INVALID = 3'd3,
        KIND_LIST_END      = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] mode;
        logic [7:0] pid;
        logic       pid_present;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       empty_response;
    } item_t;

    typedef struct packed {
        kind_t              result_kind;
        logic [2:0]         target;
        logic signed [14:0] value;
        logic [1:0]         dtc_family;
        logic [13:0]        dtc_digits;
        logic [5:0]         dtc_slot;
        logic               mil_on;
        logic [6:0]         reported_count;
        logic               diesel_engine;
        logic [5:0]         common_monitors;
        logic [15:0]        specific_monitors;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [2:0]  byte_position;
        logic [23:0] held_bytes;
        logic [6:0]  code_count;
        logic        codes_stopped;
    } state_t;

endpackage

/* rtl/core/obd2rd_decode.sv */
// Combinational decode of one payload word against the current decoder state.
// Produces up to two results and the next state; depends on obd2rd_pkg.
module obd2rd_decode
    import obd2rd_pkg::*;
(
    input  item_t      item,
    input  state_t     state_in,
    output logic [1:0] result_count,
    output result_t    result0,
    output result_t    result1,
    output state_t     state_out
);

    function automatic logic [1:0] monitor_code(input logic sup, input logic inc);
        logic [1:0] code;
        if (!sup)
        begin
            code = 2'd0;
        end
        else
        begin
            code = inc ? 2'd1 : 2'd2;
        end
        return code;
    endfunction

    function automatic result_t readiness(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d);
        result_t r;
        r = '0;
        r.result_kind = KIND_READY_VALID;
        r.mil_on = a[7];
        r.reported_count = a[6:0];
        r.diesel_engine = b[3];
        for (int i = 0; i < 3; i++)
        begin
            r.common_monitors[2*i +: 2] = monitor_code(b[i], b[4+i]);
        end
        for (int i = 0; i < 8; i++)
        begin
            if (!(b[3] && i >= 6))
            begin
                r.specific_monitors[2*i +: 2] = monitor_code(c[i], d[i]);
            end
        end
        return r;
    endfunction

    logic        is_ready;
    logic        list_hit;
    logic [2:0]  list_tgt;
    logic [2:0]  pos;
    logic [7:0]  d;
    logic [23:0] held_ins;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [15:0] prod;
    logic [16:0] quot;
    state_t      st;
    result_t     r0;
    result_t     r1;
    result_t     rend;
    logic [1:0]  n;

    always_comb
    begin
        case (item.mode)
            MODE_STORED:
            begin
                list_hit = 1'b1;
                list_tgt = TGT_STORED;
            end
            MODE_PENDING:
            begin
                list_hit = 1'b1;
                list_tgt = TGT_PENDING;
            end
            MODE_PERMANENT:
            begin
                list_hit = 1'b1;
                list_tgt = TGT_PERMANENT;
            end
            default:
            begin
                list_hit = 1'b0;
                list_tgt = 3'd0;
            end
        endcase
    end

    always_comb
    begin
        is_ready = (item.mode == MODE_CURRENT) && item.pid_present && (item.pid == PID_MONITORS);
        d = item.data_byte;
        st = state_in;
        r0 = '0;
        r1 = '0;
        rend = '0;
        n = 2'd0;
        pos = 3'd0;
        held_ins = '0;
        d0 = '0;
        d1 = '0;
        prod = '0;
        quot = '0;
        if (item.empty_response)
        begin
            st = '0;
            if (is_ready)
            begin
                n = 2'd1;
                r0.result_kind = KIND_READY_INVALID;
            end
            else if (list_hit)
            begin
                n = 2'd1;
                r0.result_kind = KIND_LIST_END;
                r0.target = list_tgt;
            end
        end
        else
        begin
            if (item.first_byte)
            begin
                st = '0;
            end
            pos = st.byte_position;
            held_ins = st.held_bytes;
            if (pos < 3'd3)
            begin
                held_ins = st.held_bytes | (24'(d) << {pos[1:0], 3'b000});
            end
            if (is_ready)
            begin
                st.held_bytes = held_ins;
                if (pos == 3'd3)
                begin
                    n = 2'd1;
                    r0 = readiness(held_ins[7:0], held_ins[15:8], held_ins[23:16], d);
                end
                else if (item.last_byte && pos < 3'd3)
                begin
                    n = 2'd1;
                    r0.result_kind = KIND_READY_INVALID;
                end
            end
            else if (list_hit)
            begin
                if (!pos[0])
                begin
                    st.held_bytes = {16'd0, d};
                end
                else if (!st.codes_stopped && st.code_count < 7'(MAX_DTC))
                begin
                    if (st.held_bytes[7:0] == 8'd0 && d == 8'd0)
                    begin
                        st.codes_stopped = 1'b1;
                    end
                    else
                    begin
                        n = 2'd1;
                        r0.result_kind = KIND_DTC_ENTRY;
                        r0.dtc_family = st.held_bytes[7:6];
                        r0.dtc_digits = {st.held_bytes[5:0], d};
                        r0.dtc_slot = st.code_count[5:0];
                        st.code_count = st.code_count + 7'd1;
                    end
                end
                if (item.last_byte)
                begin
                    rend.result_kind = KIND_LIST_END;
                    rend.target = list_tgt;
                    rend.value = 15'(st.code_count);
                    if (n == 2'd1)
                    begin
                        r1 = rend;
                        n = 2'd2;
                    end
                    else
                    begin
                        r0 = rend;
                        n = 2'd1;
                    end
                end
            end
            else
            begin
                st.held_bytes = held_ins;
                d0 = held_ins[7:0];
                d1 = held_ins[15:8];
                prod = 16'(d0) * 16'd100;
                quot = (17'(prod) + 17'(prod >> 8) + 17'd1) >> 8;
                if (item.last_byte && item.pid_present)
                begin
                    r0.result_kind = KIND_SCALAR;
                    case (item.pid)
                        PID_RPM:
                        begin
                            if (pos >= 3'd1)
                            begin
                                n = 2'd1;
                                r0.target = TGT_RPM;
                                r0.value = 15'({d0, d1} >> 2);
                            end
                        end
                        PID_SPEED:
                        begin
                            n = 2'd1;
                            r0.target = TGT_SPEED;
                            r0.value = 15'(d0);
                        end
                        PID_COOLANT:
                        begin
                            n = 2'd1;
                            r0.target = TGT_COOLANT;
                            r0.value = 15'(d0) - 15'd40;
                        end
                        PID_FUEL:
                        begin
                            n = 2'd1;
                            r0.target = TGT_FUEL;
                            r0.value = 15'(quot);
                        end
                        PID_LOAD:
                        begin
                            n = 2'd1;
                            r0.target = TGT_LOAD;
                            r0.value = 15'(quot);
                        end
                        default:
                        begin
                            n = 2'd0;
                        end
                    endcase
                end
            end
            st.byte_position = (pos < 3'd4) ? pos + 3'd1 : (pos ^ 3'd1);
            if (item.last_byte)
            begin
                st = '0;
            end
        end
    end

    assign result_count = n;
    assign result0 = r0;
    assign result1 = r1;
    assign state_out = st;

endmodule

/* rtl/core/obd2_response_decoder.sv */
// OBD-II response decoder top level: input register, decode, result register.
// Instantiates obd2rd_decode; depends on obd2rd_pkg.
//
// Each input word is one payload byte tagged with mode and PID. A word that
// yields one result or none leaves the input register as its result, if any,
// is registered, so a word can be taken every cycle unless the output stalls.
// The byte that closes a DTC list while also completing a code yields two
// results and holds the input register until both are registered, since the
// result register delivers one result per cycle.
module obd2_response_decoder
    import obd2rd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    input  logic [18:0] s_tuser,   // mode[7:0], pid[15:8], pid_present[16],
                                   // first_byte[17], empty_response[18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // value[14:0], dtc_family[16:15], dtc_digits[30:17],
                                   // dtc_slot[36:31], mil_on[37], reported_count[44:38],
                                   // diesel_engine[45], common_monitors[51:46],
                                   // specific_monitors[67:52], zero[71:68]
    output logic        m_tlast,
    output logic [5:0]  m_tuser    // result_kind[2:0], target[5:3]
);

    item_t      in_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic       sub_reg;
    logic       sub_next;
    state_t     state_reg;
    state_t     state_next;
    result_t    out_reg;
    result_t    out_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    item_t      s_item;
    logic       s_accept;
    logic       out_load;
    logic       emit;
    logic       in_done;
    logic       last_sub;
    logic [1:0] dec_count;
    result_t    dec_res0;
    result_t    dec_res1;
    state_t     dec_state;

    obd2rd_decode u_decode (
        .item         (in_reg),
        .state_in     (state_reg),
        .result_count (dec_count),
        .result0      (dec_res0),
        .result1      (dec_res1),
        .state_out    (dec_state)
    );

    always_comb
    begin
        s_item.mode = s_tuser[7:0];
        s_item.pid = s_tuser[15:8];
        s_item.pid_present = s_tuser[16];
        s_item.data_byte = s_tdata;
        s_item.first_byte = s_tuser[17];
        s_item.last_byte = s_tlast;
        s_item.empty_response = s_tuser[18];
    end

    always_comb
    begin
        last_sub = (dec_count == 2'd2);
        out_load = !out_valid_reg || m_tready;
        emit = in_valid_reg && (dec_count != 2'd0) && out_load;
        in_done = in_valid_reg && ((dec_count == 2'd0) || (emit && (sub_reg == last_sub)));
        s_tready = !in_valid_reg || in_done;
        s_accept = s_tvalid && s_tready;

        in_valid_next = s_accept ? 1'b1 : (in_done ? 1'b0 : in_valid_reg);
        sub_next = in_done ? 1'b0 : (emit ? 1'b1 : sub_reg);
        state_next = in_done ? dec_state : state_reg;
        out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

        out_next = sub_reg ? dec_res1 : dec_res0;
        out_next.last_of_run = (sub_reg == last_sub);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            sub_reg <= 1'b0;
            state_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            sub_reg <= sub_next;
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_reg <= s_item;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast = out_reg.last_of_run;
    assign m_tuser = {out_reg.target, out_reg.result_kind};
    assign m_tdata = {4'd0,
                      out_reg.specific_monitors,
                      out_reg.common_monitors,
                      out_reg.diesel_engine,
                      out_reg.reported_count,
                      out_reg.mil_on,
                      out_reg.dtc_slot,
                      out_reg.dtc_digits,
                      out_reg.dtc_family,
                      out_reg.value};

endmodule
